// File: rtl/wsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer: parse phases,
// result kinds and the record that passes from the parser to the output side.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Width of the decoded payload length (top bit of the 64-bit field dropped)
  localparam int unsigned LenW = 63;
  localparam int unsigned KeyW = 32;

  // Short length codes that announce an extended length
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // Byte counts of the extended length and of the masking key
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExtLen  = 3'd2,
    PhKey     = 3'd3,
    PhPayload = 3'd4
  } wsd_phase_e;

  typedef enum logic {
    KindHeader  = 1'b0,
    KindPayload = 1'b1
  } wsd_kind_e;

  // One pending result: raw byte and key byte, unmasked on the output side
  typedef struct packed {
    wsd_kind_e         kind;
    logic [7:0]        data;
    logic [7:0]        key;
    logic              fin;
    logic [3:0]        opcode;
    logic              masked;
    logic [LenW-1:0]   length;
    logic              last;
  } wsd_entry_t;

endpackage
`default_nettype wire

// File: rtl/wsd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels of the deframer: the received byte stream and the
// stream of header and payload results.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [7:0]                out_byte;
  logic                      final_fragment;
  logic [3:0]                frame_opcode;
  logic                      was_masked;
  logic [wsd_pkg::LenW-1:0]  frame_length;
  logic                      last_byte;

  modport source (
    output valid, output kind, output out_byte, output final_fragment,
    output frame_opcode, output was_masked, output frame_length,
    output last_byte, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input final_fragment,
    input frame_opcode, input was_masked, input frame_length,
    input last_byte, output ready
  );
endinterface
`default_nettype wire

// File: rtl/wsd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_front
// Frame header parser. Takes one byte per beat, tracks the parse phase,
// collects the extended length and masking key, and pushes one record per
// header completion or payload byte.
// ----------------------------------------------------------------------------
module wsd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          byte_i,
  output      logic                push_o,
  output      wsd_pkg::wsd_entry_t entry_o
);

  wsd_pkg::wsd_phase_e             phase_q, phase_d;
  logic                            fin_q, fin_d;
  logic [3:0]                      op_q, op_d;
  logic                            mask_q, mask_d;
  logic [wsd_pkg::LenW-1:0]        len_q, len_d;
  logic [3:0]                      ext_q, ext_d;
  logic [wsd_pkg::KeyW-1:0]        key_q, key_d;
  logic [wsd_pkg::LenW-1:0]        left_q, left_d;
  logic [1:0]                      kidx_q, kidx_d;

  logic [6:0]                      len7;
  logic [wsd_pkg::LenW-1:0]        len_ext;
  logic [3:0]                      ext_dec;
  logic                            is_code;
  logic                            hdr_done;
  logic [wsd_pkg::LenW-1:0]        hdr_len;
  logic                            hdr_empty;
  logic                            pay_last;
  logic [7:0]                      key_byte;

  assign len7      = byte_i[6:0];
  assign len_ext   = {len_q[wsd_pkg::LenW-9:0], byte_i};
  assign ext_dec   = ext_q - 4'd1;
  assign is_code   = (len7 == wsd_pkg::Len16Code) || (len7 == wsd_pkg::Len64Code);
  assign hdr_empty = (hdr_len == '0);
  assign pay_last  = (left_q == wsd_pkg::LenW'(1));
  // First key byte sits in the top byte
  assign key_byte  = key_q[{~kidx_q, 3'b000} +: 8];

  // Detect the byte that completes a header and the length it carries
  always_comb begin
    hdr_done = 1'b0;
    hdr_len  = len_q;
    case (phase_q)
      wsd_pkg::PhHdr1: begin
        hdr_done = !is_code && !byte_i[7];
        hdr_len  = wsd_pkg::LenW'(len7);
      end
      wsd_pkg::PhExtLen: begin
        hdr_done = (ext_dec == '0) && !mask_q;
        hdr_len  = len_ext;
      end
      wsd_pkg::PhKey: begin
        hdr_done = (ext_dec == '0);
      end
      default: begin
        hdr_done = 1'b0;
      end
    endcase
  end

  // Next parse phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        wsd_pkg::PhHdr1: begin
          if (is_code) begin
            phase_d = wsd_pkg::PhExtLen;
          end else if (byte_i[7]) begin
            phase_d = wsd_pkg::PhKey;
          end else begin
            phase_d = hdr_empty ? wsd_pkg::PhHdr0 : wsd_pkg::PhPayload;
          end
        end
        wsd_pkg::PhExtLen: begin
          if (ext_dec == '0) begin
            if (mask_q) begin
              phase_d = wsd_pkg::PhKey;
            end else begin
              phase_d = hdr_empty ? wsd_pkg::PhHdr0 : wsd_pkg::PhPayload;
            end
          end
        end
        wsd_pkg::PhKey: begin
          if (ext_dec == '0) begin
            phase_d = hdr_empty ? wsd_pkg::PhHdr0 : wsd_pkg::PhPayload;
          end
        end
        wsd_pkg::PhPayload: begin
          if (pay_last) begin
            phase_d = wsd_pkg::PhHdr0;
          end
        end
        default: begin
          phase_d = wsd_pkg::PhHdr1;
        end
      endcase
    end
  end

  // Field registers and the pushed record
  always_comb begin
    fin_d  = fin_q;
    op_d   = op_q;
    mask_d = mask_q;
    len_d  = len_q;
    ext_d  = ext_q;
    key_d  = key_q;
    left_d = left_q;
    kidx_d = kidx_q;
    push_o = 1'b0;

    if (accept_i) begin
      case (phase_q)
        wsd_pkg::PhHdr1: begin
          mask_d = byte_i[7];
          if (len7 == wsd_pkg::Len16Code) begin
            len_d = '0;
            ext_d = wsd_pkg::Ext16Bytes;
          end else if (len7 == wsd_pkg::Len64Code) begin
            len_d = '0;
            ext_d = wsd_pkg::Ext64Bytes;
          end else begin
            len_d = wsd_pkg::LenW'(len7);
            if (byte_i[7]) begin
              ext_d = wsd_pkg::KeyBytes;
            end
          end
        end
        wsd_pkg::PhExtLen: begin
          len_d = len_ext;
          ext_d = ((ext_dec == '0) && mask_q) ? wsd_pkg::KeyBytes : ext_dec;
        end
        wsd_pkg::PhKey: begin
          key_d = {key_q[wsd_pkg::KeyW-9:0], byte_i};
          ext_d = ext_dec;
        end
        wsd_pkg::PhPayload: begin
          kidx_d = kidx_q + 2'd1;
          left_d = left_q - wsd_pkg::LenW'(1);
          push_o = 1'b1;
        end
        default: begin
          fin_d  = byte_i[7];
          op_d   = byte_i[3:0];
          mask_d = 1'b0;
          len_d  = '0;
          key_d  = '0;
          kidx_d = '0;
          ext_d  = '0;
          left_d = '0;
        end
      endcase

      // Header complete: arm the payload counter
      if (hdr_done) begin
        push_o = 1'b1;
        kidx_d = '0;
        ext_d  = '0;
        left_d = hdr_len;
      end
    end
  end

  // Build the record for the output side
  always_comb begin
    entry_o.kind   = wsd_pkg::KindHeader;
    entry_o.data   = '0;
    entry_o.key    = '0;
    entry_o.fin    = fin_q;
    entry_o.opcode = op_q;
    entry_o.masked = mask_d;
    entry_o.length = len_d;
    entry_o.last   = hdr_empty;
    if (phase_q == wsd_pkg::PhPayload) begin
      entry_o.kind = wsd_pkg::KindPayload;
      entry_o.data = byte_i;
      entry_o.key  = key_byte;
      entry_o.last = pay_last;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsd_pkg::PhHdr0;
      fin_q   <= 1'b0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      ext_q   <= '0;
      key_q   <= '0;
      left_q  <= '0;
      kidx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      ext_q   <= ext_d;
      key_q   <= key_d;
      left_q  <= left_d;
      kidx_q  <= kidx_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wsd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_queue
// Short first-in first-out queue of result records between the parser and
// the output stage.
// ----------------------------------------------------------------------------
module wsd_queue #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire wsd_pkg::wsd_entry_t entry_i,
  output      logic                full_o,
  input  wire logic                pop_i,
  output      logic                valid_o,
  output      wsd_pkg::wsd_entry_t entry_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  wsd_pkg::wsd_entry_t mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store records
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wsd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_back
// Output stage. Pops records from the queue, unmasks payload bytes and holds
// each result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire wsd_pkg::wsd_entry_t entry_i,
  output      logic                pop_o,
  wsd_out_if.source                out_o
);

  logic                     valid_q, valid_d;
  logic                     kind_q;
  logic [7:0]               byte_q;
  logic                     fin_q;
  logic [3:0]               op_q;
  logic                     mask_q;
  logic [wsd_pkg::LenW-1:0] len_q;
  logic                     last_q;

  // Load when the output register is empty or being drained
  assign pop_o = valid_i && (!valid_q || out_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unmask and hold the result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= entry_i.kind;
      byte_q <= entry_i.data ^ entry_i.key;
      fin_q  <= entry_i.fin;
      op_q   <= entry_i.opcode;
      mask_q <= entry_i.masked;
      len_q  <= entry_i.length;
      last_q <= entry_i.last;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.kind           = kind_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.final_fragment = fin_q;
  assign out_o.frame_opcode   = op_q;
  assign out_o.was_masked     = mask_q;
  assign out_o.frame_length   = len_q;
  assign out_o.last_byte      = last_q;

endmodule
`default_nettype wire

// File: rtl/websocket_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser and payload unmasker.
//
// in_i takes the received stream, one byte per beat. out_o gives one result
// per header (kind 0, out_byte 0) and one per payload byte (kind 1, byte
// already unmasked), each with the frame's FIN, opcode, mask flag and
// decoded length; last_byte marks the final payload byte, or the header of
// an empty frame. Header bytes other than the completing one give no result.
// Throughput is one byte per cycle while the queue is not full. An accepted
// byte's result is written into the queue, then loaded into the output
// register, where it is held until the receiver takes it.
// When the receiver stalls, results collect in the QueueDepth-entry queue
// behind the output register; in_i.ready drops once the queue is full.
// Reset (asynchronous, active low) empties the queue and the output
// register and makes the parser wait for the first byte of a frame header.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wsd_in_if.sink    in_i,
  wsd_out_if.source out_o
);

  logic                in_fire;
  logic                push;
  wsd_pkg::wsd_entry_t push_entry;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  wsd_pkg::wsd_entry_t q_entry;

  assign in_i.ready = !q_full;
  assign in_fire    = in_i.valid && in_i.ready;

  wsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .byte_i   (in_i.in_byte),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  wsd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  wsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // Pop only from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // An empty queue stays empty when no byte was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && !q_valid) |=> !q_valid)
    else $error("queue filled without an accepted byte");

  // A header result that is not last belongs to a non-empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == wsd_pkg::KindHeader) && !out_o.last_byte)
      |-> (out_o.frame_length != '0))
    else $error("header of non-empty frame has zero length");

  // Header results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == wsd_pkg::KindHeader)) |-> (out_o.out_byte == 8'd0))
    else $error("header result carries a data byte");

endmodule
`default_nettype wire

// File: test/tb_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking bench for the WebSocket receive deframer. A parser class
// tracks frame headers and payload unmasking, and queues the header and
// payload results that each accepted byte causes. Every result taken from
// the block is checked against the oldest queued result. The stream opens
// with a few hand-built frames. Random frames follow, driven under several
// idle and stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 10;

  typedef enum int {LenShort, LenExt16, LenExt64} len_form_e;

  // One result as seen on the output channel
  typedef struct packed {
    wsd_kind_e        kind;
    logic [7:0]       out_byte;
    logic             fin;
    logic [3:0]       opcode;
    logic             masked;
    logic [LenW-1:0]  length;
    logic             last;
  } frame_result_t;

  // Frame parser: tracks header state and queues the results due
  class frame_scoreboard;
    wsd_phase_e       phase;
    logic             fin;
    logic [3:0]       opcode;
    logic             masked;
    logic [LenW-1:0]  length;
    logic [3:0]       bytes_left;
    logic [KeyW-1:0]  key;
    logic [LenW-1:0]  remaining;
    logic [1:0]       key_pos;
    frame_result_t    due_results[$];
    int               errors;

    function new();
      phase      = PhHdr0;
      fin        = 1'b0;
      opcode     = '0;
      masked     = 1'b0;
      length     = '0;
      bytes_left = '0;
      key        = '0;
      remaining  = '0;
      key_pos    = '0;
      errors     = 0;
    endfunction

    function void push_result(wsd_kind_e kind, logic [7:0] data, logic last);
      frame_result_t r;
      r.kind     = kind;
      r.out_byte = data;
      r.fin      = fin;
      r.opcode   = opcode;
      r.masked   = masked;
      r.length   = length;
      r.last     = last;
      due_results.push_back(r);
    endfunction

    // Emit the header result and move on to the payload, or to the next frame
    function void close_header();
      push_result(KindHeader, 8'h00, length == '0);
      key_pos    = '0;
      bytes_left = '0;
      remaining  = length;
      phase      = (length == '0) ? PhHdr0 : PhPayload;
    endfunction

    function void after_length();
      if (masked) begin
        bytes_left = KeyBytes;
        phase      = PhKey;
      end else begin
        close_header();
      end
    endfunction

    // Advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [7:0] key_byte;
      case (phase)
        PhHdr1: begin
          masked = b[7];
          length = '0;
          if (b[6:0] == Len16Code) begin
            bytes_left = Ext16Bytes;
            phase      = PhExtLen;
          end else if (b[6:0] == Len64Code) begin
            bytes_left = Ext64Bytes;
            phase      = PhExtLen;
          end else begin
            length = LenW'(b[6:0]);
            after_length();
          end
        end
        PhExtLen: begin
          length     = {length[LenW-9:0], b};
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == '0) after_length();
        end
        PhKey: begin
          key        = {key[KeyW-9:0], b};
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == '0) close_header();
        end
        PhPayload: begin
          key_byte  = key[31 - 8 * key_pos -: 8];
          key_pos   = key_pos + 2'd1;
          remaining = remaining - 1'b1;
          push_result(KindPayload, b ^ key_byte, remaining == '0);
          if (remaining == '0) phase = PhHdr0;
        end
        default: begin
          fin        = b[7];
          opcode     = b[3:0];
          masked     = 1'b0;
          length     = '0;
          key        = '0;
          key_pos    = '0;
          bytes_left = '0;
          remaining  = '0;
          phase      = PhHdr1;
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest one due
    function void check_result(frame_result_t got);
      frame_result_t exp;
      if (due_results.size() == 0) begin
        $error("result with none due: kind %0d byte %02h", got.kind, got.out_byte);
        errors++;
        return;
      end
      exp = due_results.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.fin !== exp.fin) begin
        $error("final_fragment: expected %0d, got %0d", exp.fin, got.fin);
        errors++;
      end
      if (got.opcode !== exp.opcode) begin
        $error("frame_opcode: expected %0h, got %0h", exp.opcode, got.opcode);
        errors++;
      end
      if (got.masked !== exp.masked) begin
        $error("was_masked: expected %0d, got %0d", exp.masked, got.masked);
        errors++;
      end
      if (got.length !== exp.length) begin
        $error("frame_length: expected %0d, got %0d", exp.length, got.length);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_byte: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic sink_hold;
  int   send_idle_pct;
  int   sink_stall_pct;
  int   cycles;

  logic [7:0]       stream_q[$];
  frame_scoreboard  board;

  wsd_in_if  in_ch();
  wsd_out_if out_ch();

  websocket_frame_deframer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive ready: random stalls, forced low during a hold-off
  always @(negedge clk_i) begin
    out_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  // Check each result beat as it is accepted
  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.kind     = wsd_kind_e'(out_ch.kind);
      got.out_byte = out_ch.out_byte;
      got.fin      = out_ch.final_fragment;
      got.opcode   = out_ch.frame_opcode;
      got.masked   = out_ch.was_masked;
      got.length   = out_ch.frame_length;
      got.last     = out_ch.last_byte;
      board.check_result(got);
    end
  end

  // Append one frame to the byte stream
  function automatic void queue_frame(logic [7:0] hdr0, logic masked, int unsigned len,
                                      len_form_e form);
    logic [31:0] key;
    logic [63:0] ext;
    key = $urandom;
    ext = 64'(len);
    ext[63] = 1'($urandom_range(1));
    stream_q.push_back(hdr0);
    case (form)
      LenShort: stream_q.push_back({masked, len[6:0]});
      LenExt16: begin
        stream_q.push_back({masked, Len16Code});
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
      end
      default: begin
        stream_q.push_back({masked, Len64Code});
        for (int i = 7; i >= 0; i--) stream_q.push_back(ext[8 * i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) stream_q.push_back(key[8 * i +: 8]);
    repeat (len) stream_q.push_back(8'($urandom_range(255)));
  endfunction

  // Fill the stream with random frames, mostly short ones
  function automatic void queue_random_frames(int unsigned budget);
    int unsigned pick;
    logic [7:0]  hdr0;
    logic        masked;
    while (stream_q.size() < budget) begin
      pick   = $urandom_range(99);
      hdr0   = 8'($urandom_range(255));
      masked = 1'($urandom_range(1));
      if (pick < 62)      queue_frame(hdr0, masked, $urandom_range(20), LenShort);
      else if (pick < 68) queue_frame(hdr0, masked, $urandom_range(125), LenShort);
      else if (pick < 84) queue_frame(hdr0, masked, $urandom_range(40), LenExt16);
      else                queue_frame(hdr0, masked, $urandom_range(40), LenExt64);
    end
  endfunction

  // Offer one byte, with a random idle gap ahead of it
  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_byte(b);
    @(negedge clk_i);
  endtask

  // Send the whole stream, then hold until every result is in
  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    board          = new();
    cycles         = 0;
    sink_hold      = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Hand-built frames: empty unmasked frame with all header bits set,
    // masked one-byte frame, zero length in a non-minimal 16-bit field,
    // 64-bit length with its top bit set (cleared by the block)
    stream_q = {8'hFF, 8'h00,
                8'h00, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h3C,
                8'h72, 8'h7E, 8'h00, 8'h00,
                8'h80, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                8'hFF};
    send_stream();

    // No idling; the receiver holds off at first so the queue fills up
    fork
      begin
        sink_hold = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        sink_hold = 1'b0;
      end
    join_none
    queue_random_frames(130);
    send_stream();

    // Sender idles often
    send_idle_pct = 65;
    queue_random_frames(130);
    send_stream();

    // Receiver stalls often; one long frame with a two-byte length
    send_idle_pct  = 0;
    sink_stall_pct = 65;
    queue_frame(8'h82, 1'b1, 300, LenExt16);
    queue_random_frames(330);
    send_stream();

    // Light idling on both sides
    send_idle_pct  = 7;
    sink_stall_pct = 7;
    queue_random_frames(130);
    send_stream();

    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: websocket_frame_deframer.f
rtl/wsd_pkg.sv
rtl/wsd_if.sv
rtl/wsd_front.sv
rtl/wsd_queue.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer.sv
test/tb_websocket_frame_deframer.sv
